>>> rtl/ntdf_pkg.sv
// shared types and constants for the number to digit frames block
// no dependencies; used by every rtl file of the block
package ntdf_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 8;

  // blank code for a position past the last significant digit
  localparam logic [DATA_W-1:0] BLANK_CODE = 8'h7f;

  // reciprocal of ten: floor(m * RECIP_TEN / 2^35) == m / 10 for any 32-bit m
  localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hcccc_cccd;
  localparam int unsigned RECIP_SHIFT = 35;

  // input request
  typedef struct packed {
    logic signed [VALUE_W-1:0] number;
    logic                      screen_is_first;
  } in_t;

  // one digit-write frame
  typedef struct packed {
    logic [ADDR_W-1:0] first_address;
    logic [DATA_W-1:0] first_data;
    logic [ADDR_W-1:0] second_address;
    logic [DATA_W-1:0] second_data;
    logic              last;
  } out_t;

  // magnitude form of a request, handed from the front stage to the sequencer
  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    logic               neg;
    logic               first;
  } mag_t;

  // one division step, handed from the sequencer to the formatter
  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] quo;
    logic               neg;
    logic               first;
    logic [ADDR_W-1:0]  addr;
    logic               last;
  } step_t;

endpackage

>>> rtl/ntdf_front.sv
// front stage: request register and sign/magnitude split
// depends on ntdf_pkg
module ntdf_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  ntdf_pkg::in_t in_req,
  input  logic          take,
  output logic          busy,
  output logic          s1_valid,
  output ntdf_pkg::mag_t s1
);

  logic           valid_r;
  logic           valid_nxt;
  logic           accept;
  ntdf_pkg::mag_t s1_r;
  ntdf_pkg::mag_t s1_nxt;

  // the stage frees up in the same cycle the sequencer takes its request
  assign busy   = valid_r && !take;
  assign accept = start && !busy;

  // valid bit
  always_comb begin
    valid_nxt = accept || (valid_r && !take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // magnitude and sign; the most negative value maps to 2^31, which fits unsigned
  always_comb begin
    s1_nxt.neg   = in_req.number[ntdf_pkg::VALUE_W-1];
    s1_nxt.first = in_req.screen_is_first;
    if (in_req.number[ntdf_pkg::VALUE_W-1]) begin
      s1_nxt.mag = ~unsigned'(in_req.number) + ntdf_pkg::VALUE_W'(1);
    end else begin
      s1_nxt.mag = unsigned'(in_req.number);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = valid_r;
  assign s1       = s1_r;

endmodule

>>> rtl/ntdf_divseq.sv
// divide-by-ten sequencer: one quotient per cycle through a reciprocal multiply
// depends on ntdf_pkg
module ntdf_divseq #(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            s1_valid,
  input  ntdf_pkg::mag_t  s1,
  output logic            take,
  output logic            step_valid,
  output ntdf_pkg::step_t step
);

  localparam int unsigned POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int unsigned PROD_W = 2 * ntdf_pkg::VALUE_W;
  localparam int unsigned QUO_HI = PROD_W - 1;
  localparam int unsigned QUO_LO = ntdf_pkg::RECIP_SHIFT;

  logic                        active_r;
  logic [POS_W-1:0]            pos_r;
  logic [ntdf_pkg::VALUE_W-1:0] mag_r;
  logic                        neg_r;
  logic                        first_r;
  logic                        at_end;
  logic [PROD_W-1:0]           prod;
  logic [ntdf_pkg::VALUE_W-1:0] quo;
  logic                        step_valid_r;
  ntdf_pkg::step_t             step_r;
  ntdf_pkg::step_t             step_nxt;

  assign at_end = (pos_r == POS_W'(DIGIT_COUNT - 1));
  assign take   = s1_valid && (!active_r || at_end);

  // running quotient by ten
  assign prod = PROD_W'(mag_r) * PROD_W'(ntdf_pkg::RECIP_TEN);
  assign quo  = ntdf_pkg::VALUE_W'(prod[QUO_HI:QUO_LO]);

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_r    <= '0;
    end else if (take) begin
      active_r <= 1'b1;
      pos_r    <= '0;
    end else if (active_r && at_end) begin
      active_r <= 1'b0;
    end else if (active_r) begin
      pos_r <= pos_r + POS_W'(1);
    end
  end

  // running value and request attributes
  always_ff @(posedge clk) begin
    if (take) begin
      mag_r   <= s1.mag;
      neg_r   <= s1.neg;
      first_r <= s1.first;
    end else if (active_r) begin
      mag_r <= quo;
    end
  end

  // step record for the formatter
  always_comb begin
    step_nxt.mag   = mag_r;
    step_nxt.quo   = quo;
    step_nxt.neg   = neg_r;
    step_nxt.first = first_r;
    step_nxt.addr  = ntdf_pkg::ADDR_W'(pos_r) + ntdf_pkg::ADDR_W'(1);
    step_nxt.last  = at_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_valid_r <= 1'b0;
    end else begin
      step_valid_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (active_r) begin
      step_r <= step_nxt;
    end
  end

  assign step_valid = step_valid_r;
  assign step       = step_r;

endmodule

>>> rtl/ntdf_format.sv
// formatter: remainder, sign, blanking and chip routing into the frame register
// depends on ntdf_pkg
module ntdf_format (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_valid,
  input  ntdf_pkg::step_t step,
  output logic            out_valid,
  output ntdf_pkg::out_t  out_data
);

  logic [3:0]                  rem;
  logic [ntdf_pkg::DATA_W-1:0] digit;
  logic [ntdf_pkg::DATA_W-1:0] data;
  logic                        out_valid_r;
  ntdf_pkg::out_t              out_r;
  ntdf_pkg::out_t              out_nxt;

  // remainder mag - 10*quo lies in 0..9, so four bits of the difference suffice
  assign rem = step.mag[3:0] - {step.quo[0], 3'b000} - {step.quo[2:0], 1'b0};

  // negative values give negative remainders
  always_comb begin
    if (step.neg) begin
      digit = ntdf_pkg::DATA_W'(0) - {4'b0000, rem};
    end else begin
      digit = {4'b0000, rem};
    end
  end

  // blank once the running value is exhausted
  assign data = (step.mag == '0) ? ntdf_pkg::BLANK_CODE : digit;

  // route to the selected chip, no-op pair to the other
  always_comb begin
    out_nxt.last = step.last;
    if (step.first) begin
      out_nxt.first_address  = step.addr;
      out_nxt.first_data     = data;
      out_nxt.second_address = '0;
      out_nxt.second_data    = '0;
    end else begin
      out_nxt.first_address  = '0;
      out_nxt.first_data     = '0;
      out_nxt.second_address = step.addr;
      out_nxt.second_data    = data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= step_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_valid) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/number_to_digit_frames.sv
// top level of the number to digit frames block
// depends on ntdf_pkg, ntdf_front, ntdf_divseq, ntdf_format

// Each request (start high while busy is low) yields DIGIT_COUNT digit-write
// frames on consecutive cycles, position 1 first, each marked by out_valid for
// one cycle; the receiver cannot stall, so every frame must be taken as it
// appears. A request passes the front register, the sequencer and step
// registers and the frame register on its way to the ports. With start
// held, a new request is taken as the last one reaches its final position:
// the divide-by-ten sequencer produces one quotient per cycle through a single
// 32x32 reciprocal multiplier, while one more request waits in the front register.
module number_to_digit_frames #(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  ntdf_pkg::in_t  in_req,
  output logic           out_valid,
  output ntdf_pkg::out_t out_data
);

  logic            take;
  logic            s1_valid;
  ntdf_pkg::mag_t  s1;
  logic            step_valid;
  ntdf_pkg::step_t step;

  // request register and magnitude
  ntdf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_req   (in_req),
    .take     (take),
    .busy     (busy),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  // digit sequencer
  ntdf_divseq #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_divseq (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .take       (take),
    .step_valid (step_valid),
    .step       (step)
  );

  // frame formatting and output register
  ntdf_format u_format (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (step_valid),
    .step       (step),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule
